[design/dasc_pkg.sv]
// ----------------------------------------------------------------------------
// dasc_pkg
// Shared types, codes and constants of the dual-axis servo controller.
// ----------------------------------------------------------------------------
package dasc_pkg;

    // Ring depth default and field widths
    localparam int TAPS_DEF   = 8;
    localparam int OP_W       = 2;
    localparam int ADC_W      = 12;
    localparam int TARGET_W   = 16;
    localparam int POS_W      = 32;
    localparam int RING_W     = 13;
    localparam int GAIN_W     = 12;
    localparam int OFFSET_W   = 10;
    localparam int STEP_W     = 24;
    localparam int DAC_W      = 12;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 24;

    // Fixed-point scaling
    localparam int Q16_FRAC   = 16;
    localparam int KP_FRAC    = 9;
    localparam int KD_FRAC    = 16;
    localparam int DAC_FRAC   = 8;

    // Arithmetic constants
    localparam int ENC_STEP   = 11520;
    localparam int VEL_GAIN   = 5712;
    localparam int VEL_GAIN_W = 14;
    localparam int ADC_MID    = 2048;
    localparam int DAC_MID    = 2048;
    localparam int DAC_MAX    = 4095;

    // Register reset values
    localparam logic [GAIN_W-1:0]          KP_X_RST     = 12'd140;
    localparam logic [GAIN_W-1:0]          KD_X_RST     = 12'd123;
    localparam logic [GAIN_W-1:0]          KP_Y_RST     = 12'd120;
    localparam logic [GAIN_W-1:0]          KD_Y_RST     = 12'd223;
    localparam logic signed [OFFSET_W-1:0] OFFSET_X_RST = 10'sd50;
    localparam logic signed [OFFSET_W-1:0] OFFSET_Y_RST = -10'sd15;
    localparam logic [STEP_W-1:0]          MAX_STEP_RST = 24'd98304;

    // Event codes carried in op
    typedef enum logic [OP_W-1:0] {
        OP_ENC  = 2'd0,
        OP_TACH = 2'd1,
        OP_CTRL = 2'd2,
        OP_RAMP = 2'd3
    } t_op;

    // Configuration register indexes
    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_KP_X     = 3'd0,
        CFG_KD_X     = 3'd1,
        CFG_KP_Y     = 3'd2,
        CFG_KD_Y     = 3'd3,
        CFG_OFFSET_X = 3'd4,
        CFG_OFFSET_Y = 3'd5,
        CFG_MAX_STEP = 3'd6
    } t_cfg_reg;

    // Tachometer ring write request
    typedef struct packed {
        logic                     we;
        logic signed [RING_W-1:0] entry;
    } t_tach_req;

endpackage

[design/dasc_ifs.sv]
// ----------------------------------------------------------------------------
// dasc_in_if / dasc_out_if
// Valid/ready channels for event requests and drive results.
// ----------------------------------------------------------------------------
interface dasc_in_if;
    logic                                 valid;
    logic                                 ready;
    logic [dasc_pkg::OP_W-1:0]            op;
    logic                                 axis;
    logic                                 enc_a;
    logic                                 enc_hi;
    logic                                 enc_lo;
    logic [dasc_pkg::ADC_W-1:0]           adc_sample;
    logic signed [dasc_pkg::TARGET_W-1:0] target_x;
    logic signed [dasc_pkg::TARGET_W-1:0] target_y;

    modport source (
        output valid, op, axis, enc_a, enc_hi, enc_lo, adc_sample, target_x, target_y,
        input  ready
    );
    modport sink (
        input  valid, op, axis, enc_a, enc_hi, enc_lo, adc_sample, target_x, target_y,
        output ready
    );
endinterface

interface dasc_out_if;
    logic                        valid;
    logic                        ready;
    logic                        out_axis;
    logic [dasc_pkg::DAC_W-1:0]  dac_value;
    logic                        is_ramp_result;
    logic                        at_vertex;

    modport source (
        output valid, out_axis, dac_value, is_ramp_result, at_vertex,
        input  ready
    );
    modport sink (
        input  valid, out_axis, dac_value, is_ramp_result, at_vertex,
        output ready
    );
endinterface

[design/dual_axis_servo_controller.sv]
// ----------------------------------------------------------------------------
// dual_axis_servo_controller
// Two-axis position servo: encoder counting, tachometer averaging, a
// proportional law with rate feedback, and reference ramping.
// ----------------------------------------------------------------------------
// Usage:
//   i_cmd carries one event request per handshake: encoder edge, tach sample,
//   control tick or ramp tick. Encoder edges and tach samples update state and
//   return nothing. Control ticks return a 12-bit DAC code for the addressed
//   axis; ramp ticks step both references and return the arrival flag.
//   Results leave on o_res in request order.
//   Throughput: one request per cycle unless o_res stalls. State is updated
//   from the input register, so an event sees every earlier one.
//   A result passes the input register, product stage, velocity-gain stage
//   and output register in that order before it is valid on o_res.
//   When o_res stalls, results collect in the stage registers and i_cmd
//   drops ready only once every stage holds an item.
//   Configuration: i_cfg_we writes register i_cfg_index with i_cfg_data,
//   to be used only while the block is idle; unknown indexes are ignored.
//   Reset (synchronous, active low) clears positions, references, tach lines,
//   all stage valids and loads the register defaults.
// ----------------------------------------------------------------------------
module dual_axis_servo_controller #(
    parameter int TAPS = dasc_pkg::TAPS_DEF
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_cfg_we,
    input  logic [dasc_pkg::CFG_IDX_W-1:0]    i_cfg_index,
    input  logic [dasc_pkg::CFG_DATA_W-1:0]   i_cfg_data,
    dasc_in_if.sink                           i_cmd,
    dasc_out_if.source                        o_res
);

    localparam int POS_W  = dasc_pkg::POS_W;
    localparam int GAIN_W = dasc_pkg::GAIN_W;
    localparam int SUM_W  = dasc_pkg::RING_W + $clog2(TAPS);
    localparam int E_W    = POS_W + 1;
    localparam int P1_W   = E_W + GAIN_W + 1;
    localparam int P2_W   = SUM_W + GAIN_W + 1;
    localparam int Q1_W   = P1_W - dasc_pkg::KP_FRAC;
    localparam int Q2_W   = P2_W + dasc_pkg::VEL_GAIN_W;
    localparam int Q2S_W  = Q2_W - dasc_pkg::KD_FRAC;
    localparam int U_W    = Q1_W + 1;
    localparam int D_W    = U_W - dasc_pkg::DAC_FRAC + 1;
    localparam int ADC_X_W = dasc_pkg::RING_W + 1;

    typedef struct packed {
        logic [dasc_pkg::OP_W-1:0]            op;
        logic                                 axis;
        logic                                 enc_hi;
        logic                                 enc_lo;
        logic [dasc_pkg::ADC_W-1:0]           adc_sample;
        logic signed [dasc_pkg::TARGET_W-1:0] target_x;
        logic signed [dasc_pkg::TARGET_W-1:0] target_y;
    } t_cmd;

    typedef struct packed {
        logic signed [POS_W-1:0] next_ref;
        logic                    arrived;
    } t_ramp_res;

    // Move one reference toward its target by at most max_step
    function automatic t_ramp_res ramp_step(
        input logic signed [POS_W-1:0]              cur_ref,
        input logic signed [dasc_pkg::TARGET_W-1:0] target,
        input logic [dasc_pkg::STEP_W-1:0]          max_step
    );
        t_ramp_res               res;
        logic signed [POS_W-1:0] goal;
        logic signed [E_W-1:0]   diff;
        logic [E_W-1:0]          mag;
        goal = {target, {dasc_pkg::Q16_FRAC{1'b0}}};
        diff = E_W'(goal) - E_W'(cur_ref);
        mag  = diff[E_W-1] ? E_W'(-diff) : E_W'(diff);
        if (mag > E_W'(max_step)) begin
            res.arrived  = 1'b0;
            res.next_ref = diff[E_W-1] ? cur_ref - POS_W'(max_step)
                                       : cur_ref + POS_W'(max_step);
        end else begin
            res.arrived  = 1'b1;
            res.next_ref = goal;
        end
        return res;
    endfunction

    // Configuration registers
    logic [GAIN_W-1:0]                    r_kp_x, r_kd_x, r_kp_y, r_kd_y;
    logic signed [dasc_pkg::OFFSET_W-1:0] r_offset_x, r_offset_y;
    logic [dasc_pkg::STEP_W-1:0]          r_max_step;

    // Servo state
    logic signed [POS_W-1:0] r_pos_x, r_pos_y, r_ref_x, r_ref_y;
    logic signed [SUM_W-1:0] sum_x, sum_y;
    dasc_pkg::t_tach_req     tach_req_x, tach_req_y;

    // Pipeline registers
    logic                    r_a_v;
    t_cmd                    r_a;
    logic                    r_m_v, r_m_ramp, r_m_axis, r_m_vtx;
    logic signed [P1_W-1:0]  r_m_p1;
    logic signed [P2_W-1:0]  r_m_p2;
    logic                    r_n_v, r_n_ramp, r_n_axis, r_n_vtx;
    logic signed [Q1_W-1:0]  r_n_q1;
    logic signed [Q2S_W-1:0] r_n_q2;
    logic                    r_o_v, r_o_axis, r_o_ramp, r_o_vtx;
    logic [dasc_pkg::DAC_W-1:0] r_o_dac;

    // Combinational
    logic                     adv_o, adv_n, adv_m, fire, fire_res, n_in_ready;
    logic                     is_enc, is_tach, is_ctrl, is_ramp;
    logic signed [POS_W-1:0]  enc_delta;
    logic signed [POS_W-1:0]  sel_ref, sel_pos;
    logic signed [SUM_W-1:0]  sel_sum;
    logic [GAIN_W-1:0]        sel_kp, sel_kd;
    logic signed [E_W-1:0]    err;
    logic signed [P1_W-1:0]   n_p1;
    logic signed [P2_W-1:0]   n_p2;
    logic signed [Q2_W-1:0]   n_q2_full;
    logic signed [ADC_X_W-1:0] entry_base;
    logic signed [dasc_pkg::OFFSET_W-1:0] sel_offset;
    logic signed [dasc_pkg::RING_W-1:0]   tach_entry;
    t_ramp_res                ramp_x, ramp_y;
    logic signed [U_W-1:0]    u_val;
    logic signed [D_W-1:0]    d_val;
    logic [dasc_pkg::DAC_W-1:0] n_dac;

    // Write configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_kp_x     <= dasc_pkg::KP_X_RST;
            r_kd_x     <= dasc_pkg::KD_X_RST;
            r_kp_y     <= dasc_pkg::KP_Y_RST;
            r_kd_y     <= dasc_pkg::KD_Y_RST;
            r_offset_x <= dasc_pkg::OFFSET_X_RST;
            r_offset_y <= dasc_pkg::OFFSET_Y_RST;
            r_max_step <= dasc_pkg::MAX_STEP_RST;
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                dasc_pkg::CFG_KP_X:     r_kp_x     <= i_cfg_data[GAIN_W-1:0];
                dasc_pkg::CFG_KD_X:     r_kd_x     <= i_cfg_data[GAIN_W-1:0];
                dasc_pkg::CFG_KP_Y:     r_kp_y     <= i_cfg_data[GAIN_W-1:0];
                dasc_pkg::CFG_KD_Y:     r_kd_y     <= i_cfg_data[GAIN_W-1:0];
                dasc_pkg::CFG_OFFSET_X: r_offset_x <= i_cfg_data[dasc_pkg::OFFSET_W-1:0];
                dasc_pkg::CFG_OFFSET_Y: r_offset_y <= i_cfg_data[dasc_pkg::OFFSET_W-1:0];
                dasc_pkg::CFG_MAX_STEP: r_max_step <= i_cfg_data[dasc_pkg::STEP_W-1:0];
                default: ;
            endcase
        end
    end

    // Stage flow: a stage advances when it is empty or its successor advances
    always_comb begin
        is_enc     = (r_a.op == dasc_pkg::OP_ENC);
        is_tach    = (r_a.op == dasc_pkg::OP_TACH);
        is_ctrl    = (r_a.op == dasc_pkg::OP_CTRL);
        is_ramp    = (r_a.op == dasc_pkg::OP_RAMP);
        adv_o      = !r_o_v || o_res.ready;
        adv_n      = !r_n_v || adv_o;
        adv_m      = !r_m_v || adv_n;
        fire       = r_a_v && (is_enc || is_tach || adv_m);
        fire_res   = fire && (is_ctrl || is_ramp);
        n_in_ready = !r_a_v || fire;
    end

    assign i_cmd.ready = n_in_ready;

    // Capture the request
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_a_v <= 1'b0;
        end else if (n_in_ready) begin
            r_a_v <= i_cmd.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (n_in_ready && i_cmd.valid) begin
            r_a.op         <= i_cmd.op;
            r_a.axis       <= i_cmd.axis;
            r_a.enc_hi     <= i_cmd.enc_hi;
            r_a.enc_lo     <= i_cmd.enc_lo;
            r_a.adc_sample <= i_cmd.adc_sample;
            r_a.target_x   <= i_cmd.target_x;
            r_a.target_y   <= i_cmd.target_y;
        end
    end

    // Decode the event and form the axis operands
    always_comb begin
        enc_delta = (r_a.enc_hi == r_a.enc_lo) ? POS_W'(dasc_pkg::ENC_STEP)
                                               : -POS_W'(dasc_pkg::ENC_STEP);
        sel_ref    = r_a.axis ? r_ref_y : r_ref_x;
        sel_pos    = r_a.axis ? r_pos_y : r_pos_x;
        sel_sum    = r_a.axis ? sum_y   : sum_x;
        sel_kp     = r_a.axis ? r_kp_y  : r_kp_x;
        sel_kd     = r_a.axis ? r_kd_y  : r_kd_x;
        sel_offset = r_a.axis ? r_offset_y : r_offset_x;

        // Position error and the two gain products
        err  = E_W'(sel_ref) - E_W'(sel_pos);
        n_p1 = P1_W'(err) * P1_W'($signed({1'b0, sel_kp}));
        n_p2 = P2_W'(sel_sum) * P2_W'($signed({1'b0, sel_kd}));

        // Offset-corrected tach entry
        entry_base = $signed(ADC_X_W'(r_a.adc_sample)) - ADC_X_W'(dasc_pkg::ADC_MID)
                   + ADC_X_W'(sel_offset);
        tach_entry = entry_base[dasc_pkg::RING_W-1:0];

        ramp_x = ramp_step(r_ref_x, r_a.target_x, r_max_step);
        ramp_y = ramp_step(r_ref_y, r_a.target_y, r_max_step);

        tach_req_x.we    = fire && is_tach && !r_a.axis;
        tach_req_x.entry = tach_entry;
        tach_req_y.we    = fire && is_tach && r_a.axis;
        tach_req_y.entry = tach_entry;
    end

    dasc_tach #(.TAPS(TAPS)) u_tach_x (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (tach_req_x),
        .o_sum   (sum_x)
    );

    dasc_tach #(.TAPS(TAPS)) u_tach_y (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (tach_req_y),
        .o_sum   (sum_y)
    );

    // Update positions and references
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pos_x <= '0;
            r_pos_y <= '0;
            r_ref_x <= '0;
            r_ref_y <= '0;
        end else if (fire) begin
            if (is_enc) begin
                if (r_a.axis) begin
                    r_pos_y <= r_pos_y + enc_delta;
                end else begin
                    r_pos_x <= r_pos_x + enc_delta;
                end
            end
            if (is_ramp) begin
                r_ref_x <= ramp_x.next_ref;
                r_ref_y <= ramp_y.next_ref;
            end
        end
    end

    // Product stage
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_m_v <= 1'b0;
        end else if (adv_m) begin
            r_m_v <= fire_res;
        end
    end

    always_ff @(posedge i_clk) begin
        if (adv_m && fire_res) begin
            r_m_ramp <= is_ramp;
            r_m_axis <= r_a.axis;
            r_m_vtx  <= ramp_x.arrived && ramp_y.arrived;
            r_m_p1   <= n_p1;
            r_m_p2   <= n_p2;
        end
    end

    // Velocity gain stage: apply the tach scale to the rate term
    always_comb begin
        n_q2_full = Q2_W'(r_m_p2) * Q2_W'($signed(dasc_pkg::VEL_GAIN_W'(dasc_pkg::VEL_GAIN)));
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_n_v <= 1'b0;
        end else if (adv_n) begin
            r_n_v <= r_m_v;
        end
    end

    always_ff @(posedge i_clk) begin
        if (adv_n && r_m_v) begin
            r_n_ramp <= r_m_ramp;
            r_n_axis <= r_m_axis;
            r_n_vtx  <= r_m_vtx;
            r_n_q1   <= r_m_p1[P1_W-1:dasc_pkg::KP_FRAC];
            r_n_q2   <= n_q2_full[Q2_W-1:dasc_pkg::KD_FRAC];
        end
    end

    // Combine terms, center and saturate the drive code
    always_comb begin
        u_val = U_W'(r_n_q1) - U_W'(r_n_q2);
        d_val = D_W'($signed(u_val[U_W-1:dasc_pkg::DAC_FRAC])) + D_W'(dasc_pkg::DAC_MID);
        priority if (d_val < 0) begin
            n_dac = '0;
        end else if (d_val > D_W'(dasc_pkg::DAC_MAX)) begin
            n_dac = dasc_pkg::DAC_W'(dasc_pkg::DAC_MAX);
        end else begin
            n_dac = d_val[dasc_pkg::DAC_W-1:0];
        end
    end

    // Output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_o_v <= 1'b0;
        end else if (adv_o) begin
            r_o_v <= r_n_v;
        end
    end

    always_ff @(posedge i_clk) begin
        if (adv_o && r_n_v) begin
            r_o_ramp <= r_n_ramp;
            r_o_vtx  <= r_n_ramp && r_n_vtx;
            r_o_axis <= !r_n_ramp && r_n_axis;
            r_o_dac  <= r_n_ramp ? '0 : n_dac;
        end
    end

    assign o_res.valid          = r_o_v;
    assign o_res.out_axis       = r_o_axis;
    assign o_res.dac_value      = r_o_dac;
    assign o_res.is_ramp_result = r_o_ramp;
    assign o_res.at_vertex      = r_o_vtx;

endmodule

[design/dasc_tach.sv]
// ----------------------------------------------------------------------------
// dasc_tach
// Tachometer averaging line for one axis: a shift line of samples with a
// running sum that drops the oldest sample as a new one enters.
// ----------------------------------------------------------------------------
module dasc_tach #(
    parameter int TAPS = dasc_pkg::TAPS_DEF
) (
    input  logic                                                i_clk,
    input  logic                                                i_rst_n,
    input  dasc_pkg::t_tach_req                                 i_req,
    output logic signed [dasc_pkg::RING_W+$clog2(TAPS)-1:0]     o_sum
);

    localparam int SUM_W = dasc_pkg::RING_W + $clog2(TAPS);

    logic signed [dasc_pkg::RING_W-1:0] r_tap [TAPS];
    logic signed [SUM_W-1:0]            r_sum;
    logic signed [SUM_W-1:0]            n_sum;

    // Replace the oldest sample in the sum with the new one
    always_comb begin
        n_sum = r_sum - SUM_W'(r_tap[TAPS-1]) + SUM_W'(i_req.entry);
    end

    // Shift the line and hold the sum
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < TAPS; i++) begin
                r_tap[i] <= '0;
            end
            r_sum <= '0;
        end else if (i_req.we) begin
            r_tap[0] <= i_req.entry;
            for (int i = 1; i < TAPS; i++) begin
                r_tap[i] <= r_tap[i-1];
            end
            r_sum <= n_sum;
        end
    end

    assign o_sum = r_sum;

endmodule
